/* sv/tcc_pkg.sv */
// ----------------------------------------------------------------------------
// tcc_pkg: shared constants for the tilt-compensated compass heading unit
// Datapath widths, CORDIC stage count, arctangent table and gain removal.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int SampleWidth = 16;
  localparam int DW = SampleWidth + 16; // vector datapath width
  localparam int ZW = 34;              // angle width, 2^31 = pi
  localparam int CordicStages = 16;
  localparam int NSTG = (CordicStages > 24) ? 24 : CordicStages;
  localparam int LS = NSTG + 2;        // register depth of one CORDIC unit

  localparam logic signed [ZW-1:0] ANG_PI      = 34'sd2147483648;
  localparam logic signed [ZW-1:0] ANG_HALF_PI = 34'sd1073741824;
  localparam logic signed [63:0]   INVK_Q24    = 64'sd10188013;

  localparam logic signed [ZW-1:0] ATAN_TAB [24] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
    34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
    34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
    34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
    34'sd652,       34'sd326,       34'sd163,       34'sd81
  };

  // Remove the CORDIC gain: (v * 1/K) >>> 24.
  function automatic logic signed [DW-1:0] ungain(input logic signed [DW-1:0] v);
    logic signed [63:0] p;
    p = $signed({{(64-DW){v[DW-1]}}, v}) * INVK_Q24;
    return p[DW+23:24];
  endfunction

endpackage

/* sv/tcc_vec.sv */
// ----------------------------------------------------------------------------
// tcc_vec: pipelined vectoring CORDIC
// Angle of (x, y) and gain-corrected magnitude, one stage per iteration.
// ----------------------------------------------------------------------------
module tcc_vec (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic signed [tcc_pkg::DW-1:0]  y_i,
  input  logic signed [tcc_pkg::DW-1:0]  x_i,
  output logic                           valid_o,
  output logic signed [tcc_pkg::ZW-1:0]  z_o,
  output logic signed [tcc_pkg::DW-1:0]  mag_o
);

  localparam int N = tcc_pkg::NSTG;

  logic signed [tcc_pkg::DW-1:0] x_q [N+1];
  logic signed [tcc_pkg::DW-1:0] y_q [N+1];
  logic signed [tcc_pkg::ZW-1:0] z_q [N+1];
  logic                          zero_q [N+1];
  logic                          valid_q [N+2];
  logic signed [tcc_pkg::ZW-1:0] zf_q;
  logic signed [tcc_pkg::DW-1:0] mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N + 2; k++) valid_q[k] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
      for (int k = 1; k < N + 2; k++) valid_q[k] <= valid_q[k-1];
    end
  end

  // Turn a vector in the left half plane by pi first.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        x_q[0] <= -x_i;
        y_q[0] <= -y_i;
        z_q[0] <= (y_i >= 0) ? tcc_pkg::ANG_PI : -tcc_pkg::ANG_PI;
      end else begin
        x_q[0] <= x_i;
        y_q[0] <= y_i;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + tcc_pkg::ATAN_TAB[i];
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - tcc_pkg::ATAN_TAB[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zf_q  <= zero_q[N] ? '0 : z_q[N];
      mag_q <= zero_q[N] ? '0 : tcc_pkg::ungain(x_q[N]);
    end
  end

  assign valid_o = valid_q[N+1];
  assign z_o     = zf_q;
  assign mag_o   = mag_q;

endmodule

/* sv/tcc_rot.sv */
// ----------------------------------------------------------------------------
// tcc_rot: pipelined rotation CORDIC
// Turns (x, y) by angle z and removes the gain, one stage per iteration.
// ----------------------------------------------------------------------------
module tcc_rot (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic signed [tcc_pkg::DW-1:0]  x_i,
  input  logic signed [tcc_pkg::DW-1:0]  y_i,
  input  logic signed [tcc_pkg::ZW-1:0]  z_i,
  output logic                           valid_o,
  output logic signed [tcc_pkg::DW-1:0]  x_o,
  output logic signed [tcc_pkg::DW-1:0]  y_o
);

  localparam int N = tcc_pkg::NSTG;

  logic signed [tcc_pkg::DW-1:0] x_q [N+1];
  logic signed [tcc_pkg::DW-1:0] y_q [N+1];
  logic signed [tcc_pkg::ZW-1:0] z_q [N+1];
  logic                          valid_q [N+2];
  logic signed [tcc_pkg::DW-1:0] xf_q;
  logic signed [tcc_pkg::DW-1:0] yf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N + 2; k++) valid_q[k] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
      for (int k = 1; k < N + 2; k++) valid_q[k] <= valid_q[k-1];
    end
  end

  // Fold angles beyond a right angle: negate the vector, move by pi.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      priority if (z_i > tcc_pkg::ANG_HALF_PI) begin
        x_q[0] <= -x_i;
        y_q[0] <= -y_i;
        z_q[0] <= z_i - tcc_pkg::ANG_PI;
      end else if (z_i < -tcc_pkg::ANG_HALF_PI) begin
        x_q[0] <= -x_i;
        y_q[0] <= -y_i;
        z_q[0] <= z_i + tcc_pkg::ANG_PI;
      end else begin
        x_q[0] <= x_i;
        y_q[0] <= y_i;
        z_q[0] <= z_i;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - tcc_pkg::ATAN_TAB[i];
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + tcc_pkg::ATAN_TAB[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xf_q <= tcc_pkg::ungain(x_q[N]);
      yf_q <= tcc_pkg::ungain(y_q[N]);
    end
  end

  assign valid_o = valid_q[N+1];
  assign x_o     = xf_q;
  assign y_o     = yf_q;

endmodule

/* sv/tilt_compensated_compass_heading_unit.sv */
// ----------------------------------------------------------------------------
// tilt_compensated_compass_heading_unit: tilt-compensated e-compass
// Roll, pitch and heading from one accelerometer and magnetometer sample.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with six signed 16-bit sensor axes.
// Output channel: out_valid_o / out_stall_i with roll, pitch and heading as
// signed 16-bit binary angles (32768 = pi).
// One item enters per cycle while in_stall_o is low. The path is an axis remap
// register, four chained CORDIC units (roll vectoring; pitch vectoring beside
// the roll rotation of the magnetic vector; pitch rotation; heading
// vectoring), each with a quadrant fold register, one register per iteration
// and a gain removal register, and an output register.
// Reset clears all valid bits; the pipeline comes up empty and ready.
// When the receiver stalls with a result waiting, the whole pipeline holds,
// empty slots included, and the input is stalled until the result is taken.
// ----------------------------------------------------------------------------
module tilt_compensated_compass_heading_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic signed [tcc_pkg::SampleWidth-1:0] accel_x_i,
  input  logic signed [tcc_pkg::SampleWidth-1:0] accel_y_i,
  input  logic signed [tcc_pkg::SampleWidth-1:0] accel_z_i,
  input  logic signed [tcc_pkg::SampleWidth-1:0] mag_x_i,
  input  logic signed [tcc_pkg::SampleWidth-1:0] mag_y_i,
  input  logic signed [tcc_pkg::SampleWidth-1:0] mag_z_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [15:0] roll_angle_o,
  output logic signed [15:0] pitch_angle_o,
  output logic signed [15:0] heading_angle_o
);

  localparam int DW = tcc_pkg::DW;
  localparam int ZW = tcc_pkg::ZW;
  localparam int LS = tcc_pkg::LS;
  localparam int SW = tcc_pkg::SampleWidth;

  logic en;
  logic rv_q, out_valid_q;
  logic signed [DW-1:0] ax_q, ay_q, az_q, mx_q, my_q, mz_q;

  logic v1, v2, v3, v4, v5;
  logic signed [ZW-1:0] roll, pitch, heading;
  logic signed [DW-1:0] r, u, w, d, mag2, mag3, dy;

  logic signed [DW-1:0] ax_d [LS];
  logic signed [DW-1:0] my_d [LS];
  logic signed [DW-1:0] mz_d [LS];
  logic signed [DW-1:0] mx_d [2*LS];
  logic signed [DW-1:0] w_d [LS];
  logic signed [ZW-1:0] pitch_d [2*LS];
  logic signed [ZW-1:0] roll_d [3*LS];

  logic signed [15:0] roll_q, pitch_q, heading_q;

  assign en         = ~(out_valid_q & out_stall_i);
  assign in_stall_o = ~en;

  function automatic logic signed [DW-1:0] scale(input logic signed [SW-1:0] s);
    return {{(DW-SW-8){s[SW-1]}}, s, 8'b0};
  endfunction

  function automatic logic signed [15:0] to_bam(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] t;
    t = z + ZW'(32768);
    return t[31:16];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      rv_q        <= in_valid_i;
      out_valid_q <= v5;
    end
  end

  // Remap axes: x = sensor y, y = -sensor z, z = sensor x.
  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q <= scale(accel_y_i);
      ay_q <= -scale(accel_z_i);
      az_q <= scale(accel_x_i);
      mx_q <= scale(mag_y_i);
      my_q <= -scale(mag_z_i);
      mz_q <= scale(mag_x_i);
    end
  end

  // Side delay lines that keep operands aligned with the CORDIC units.
  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_d[0]    <= ax_q;
      my_d[0]    <= my_q;
      mz_d[0]    <= mz_q;
      mx_d[0]    <= mx_q;
      w_d[0]     <= w;
      pitch_d[0] <= pitch;
      roll_d[0]  <= roll;
      for (int k = 1; k < LS; k++) begin
        ax_d[k] <= ax_d[k-1];
        my_d[k] <= my_d[k-1];
        mz_d[k] <= mz_d[k-1];
        w_d[k]  <= w_d[k-1];
      end
      for (int k = 1; k < 2*LS; k++) begin
        mx_d[k]    <= mx_d[k-1];
        pitch_d[k] <= pitch_d[k-1];
      end
      for (int k = 1; k < 3*LS; k++) roll_d[k] <= roll_d[k-1];
    end
  end

  tcc_vec u_roll (
    .clk_i, .rst_ni, .en_i(en), .valid_i(rv_q),
    .y_i(ay_q), .x_i(az_q),
    .valid_o(v1), .z_o(roll), .mag_o(r)
  );

  tcc_vec u_pitch (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1),
    .y_i(-ax_d[LS-1]), .x_i(r),
    .valid_o(v2), .z_o(pitch), .mag_o(mag2)
  );

  tcc_rot u_mag_roll (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1),
    .x_i(mz_d[LS-1]), .y_i(my_d[LS-1]), .z_i(-roll),
    .valid_o(v3), .x_o(u), .y_o(w)
  );

  tcc_rot u_mag_pitch (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v3 & v2),
    .x_i(mx_d[2*LS-1]), .y_i(u), .z_i(-pitch),
    .valid_o(v4), .x_o(d), .y_o(dy)
  );

  tcc_vec u_heading (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4),
    .y_i(-w_d[LS-1]), .x_i(d),
    .valid_o(v5), .z_o(heading), .mag_o(mag3)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q    <= to_bam(roll_d[3*LS-1]);
      pitch_q   <= to_bam(pitch_d[2*LS-1]);
      heading_q <= to_bam(heading);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign roll_angle_o    = roll_q;
  assign pitch_angle_o   = pitch_q;
  assign heading_angle_o = heading_q;

endmodule
